// ----- design/pal_idx_pkg.sv -----
// Package for the palette indexer: shared types, register codes and helper functions.
// Used by pal_idx_cell and palette_indexer; depends on nothing.
package pal_idx_pkg;

  localparam int unsigned MaxPaletteSize = 256;
  localparam int unsigned ColorW = 24;
  localparam int unsigned ChanW = 8;
  localparam int unsigned IndexW = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned DistW = 10;
  localparam int unsigned BppW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegGreyscale = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTranspEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTranspColor = 2'd2;

  localparam logic [DistW-1:0] DistMax = '1;

  // One pixel word walking down the cell chain with its running search result.
  typedef struct packed {
    logic              valid;
    logic [ColorW-1:0] color;
    logic              found;
    logic [DistW-1:0]  best_dist;
    logic [IndexW-1:0] best_idx;
  } token_t;

  // Palette write broadcast to all cells.
  typedef struct packed {
    logic              en;
    logic [IndexW-1:0] idx;
    logic [ColorW-1:0] color;
  } wr_t;

  function automatic logic [ChanW-1:0] chan_diff(input logic [ChanW-1:0] a,
                                                 input logic [ChanW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DistW-1:0] l1_dist(input logic [ColorW-1:0] x,
                                               input logic [ColorW-1:0] y);
    logic [DistW-1:0] dr, dg, db;
    dr = DistW'(chan_diff(x[23:16], y[23:16]));
    dg = DistW'(chan_diff(x[15:8], y[15:8]));
    db = DistW'(chan_diff(x[7:0], y[7:0]));
    return dr + dg + db;
  endfunction

  function automatic logic [BppW-1:0] bpp_of(input logic [CountW-1:0] count);
    logic [BppW-1:0] b;
    b = BppW'(8);
    for (int k = 7; k >= 1; k--) begin
      if (count <= CountW'(1 << k)) begin
        b = BppW'(k);
      end
    end
    return b;
  endfunction

endpackage

// ----- design/palette_indexer.sv -----
// Top level of the palette indexer: configuration registers, chain of palette cells and
// result stage. Depends on pal_idx_pkg and pal_idx_cell.
//
//   Port group    Direction  Handshake                   Contents
//   pixel in      in         start / busy                red, green, blue, last_pixel
//   result out    out        done_o strobe, one cycle    index, flags, count, bpp, transparency
//   config        in         cfg_we_i                    cfg_idx_i, cfg_data_i
//
// A pixel word walks the chain of PALETTE_SIZE cells, one cell per cycle, and its result
// is registered from the tail of the chain; busy is high until the word leaves the chain,
// so a new pixel is accepted only once the previous one has left the chain.
// Reset empties the palette and clears the transparency record and registers.
// The receiver cannot stall: each result is marked valid by done_o for a single cycle.
module palette_indexer #(
  parameter int unsigned PALETTE_SIZE = pal_idx_pkg::MaxPaletteSize
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pal_idx_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pal_idx_pkg::ColorW-1:0]      cfg_data_i,
  input  logic                                start,
  output logic                                busy,
  input  logic [pal_idx_pkg::ChanW-1:0]       red_i,
  input  logic [pal_idx_pkg::ChanW-1:0]       green_i,
  input  logic [pal_idx_pkg::ChanW-1:0]       blue_i,
  input  logic                                last_pixel_i,
  output logic                                done_o,
  output logic [pal_idx_pkg::IndexW-1:0]      pixel_index_o,
  output logic                                new_entry_o,
  output logic [pal_idx_pkg::CountW-1:0]      palette_count_o,
  output logic [pal_idx_pkg::BppW-1:0]        bits_per_pixel_o,
  output logic                                transparent_found_o,
  output logic [pal_idx_pkg::IndexW-1:0]      transparent_index_o,
  output logic                                last_out_o
);
  import pal_idx_pkg::*;

  localparam int unsigned CntW = $clog2(PALETTE_SIZE + 1);

  logic              grey_q, tr_en_q;
  logic [ColorW-1:0] tr_color_q;
  logic              busy_q, done_q, last_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              hit_q, hit_d;
  logic [IndexW-1:0] slot_q, slot_d;

  token_t            tok [PALETTE_SIZE+1];
  token_t            tail;
  wr_t               wr;
  logic              accept, append, tr_set, finish;
  logic [ChanW-1:0]  g_in, b_in;
  logic [IndexW-1:0] idx_res;
  logic [CntW-1:0]   new_count;

  assign accept = start && !busy_q;
  assign busy = busy_q;
  assign g_in = grey_q ? red_i : green_i;
  assign b_in = grey_q ? red_i : blue_i;

  always_comb begin
    tok[0].valid = accept;
    tok[0].color = {red_i, g_in, b_in};
    tok[0].found = 1'b0;
    tok[0].best_dist = DistMax;
    tok[0].best_idx = '0;
  end

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
    pal_idx_cell #(
      .PaletteSize(PALETTE_SIZE),
      .CellIdx(i)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .count_i(count_q),
      .wr_i(wr),
      .tok_i(tok[i]),
      .tok_o(tok[i+1])
    );
  end

  assign tail = tok[PALETTE_SIZE];
  assign finish = tail.valid;
  assign append = !tail.found && (count_q < CntW'(PALETTE_SIZE));
  assign idx_res = append ? IndexW'(count_q) : tail.best_idx;
  assign new_count = count_q + CntW'(append);
  assign tr_set = append && tr_en_q && !hit_q && (tail.color == tr_color_q);

  always_comb begin
    wr.en = finish && append;
    wr.idx = IndexW'(count_q);
    wr.color = tail.color;
  end

  always_comb begin
    hit_d = hit_q || tr_set;
    slot_d = tr_set ? IndexW'(count_q) : slot_q;
    count_d = new_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grey_q <= 1'b0;
      tr_en_q <= 1'b0;
      tr_color_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGreyscale: grey_q <= cfg_data_i[0];
        RegTranspEnable: tr_en_q <= cfg_data_i[0];
        RegTranspColor: tr_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      count_q <= '0;
      hit_q <= 1'b0;
      slot_q <= '0;
    end else begin
      done_q <= finish;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        if (last_q) begin
          count_q <= '0;
          hit_q <= 1'b0;
          slot_q <= '0;
        end else begin
          count_q <= count_d;
          hit_q <= hit_d;
          slot_q <= slot_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last_q <= last_pixel_i;
    end
    if (finish) begin
      pixel_index_o <= idx_res;
      new_entry_o <= append;
      palette_count_o <= CountW'(new_count);
      bits_per_pixel_o <= bpp_of(CountW'(new_count));
      transparent_found_o <= hit_d;
      transparent_index_o <= slot_d;
      last_out_o <= last_q;
    end
  end

  assign done_o = done_q;

endmodule

// ----- design/pal_idx_cell.sv -----
// One cell of the palette chain: holds one palette entry and updates the passing search word.
// Depends on pal_idx_pkg.
module pal_idx_cell #(
  parameter int unsigned PaletteSize = pal_idx_pkg::MaxPaletteSize,
  parameter int unsigned CellIdx = 0
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(PaletteSize+1)-1:0]     count_i,
  input  pal_idx_pkg::wr_t                     wr_i,
  input  pal_idx_pkg::token_t                  tok_i,
  output pal_idx_pkg::token_t                  tok_o
);
  import pal_idx_pkg::*;

  localparam int unsigned CntW = $clog2(PaletteSize + 1);

  logic [ColorW-1:0] entry_q;
  logic              tok_valid_q;
  token_t            tok_d, tok_q;
  logic              active;
  logic [DistW-1:0]  cell_dist;

  assign active = count_i > CntW'(CellIdx);
  assign cell_dist = l1_dist(tok_i.color, entry_q);

  always_comb begin
    tok_d = tok_i;
    if (active && !tok_i.found) begin
      if (entry_q == tok_i.color) begin
        tok_d.found = 1'b1;
        tok_d.best_idx = IndexW'(CellIdx);
      end else if (cell_dist < tok_i.best_dist) begin
        tok_d.best_dist = cell_dist;
        tok_d.best_idx = IndexW'(CellIdx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_i.en && wr_i.idx == IndexW'(CellIdx)) begin
      entry_q <= wr_i.color;
    end
  end

  always_comb begin
    tok_o = tok_q;
    tok_o.valid = tok_valid_q;
  end

endmodule

// ----- verif/palette_indexer_tb.sv -----
// Self-checking testbench for palette_indexer: drives pixel words through the start/busy
// handshake and checks every result word against a palette predictor kept in this file.
// Depends on pal_idx_pkg and the palette_indexer RTL.
module palette_indexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pal_idx_pkg::*;

  localparam int unsigned ItemsTarget = 1700;
  localparam int unsigned CycleLimit = 3 * (ItemsTarget + 400) * (MaxPaletteSize + 16);
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last_pixel;
  } pixel_word_t;

  typedef struct packed {
    logic [IndexW-1:0] pixel_index;
    logic              new_entry;
    logic [CountW-1:0] palette_count;
    logic [BppW-1:0]   bpp;
    logic              tr_found;
    logic [IndexW-1:0] tr_index;
    logic              last_out;
  } index_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [ColorW-1:0]   cfg_data_i = '0;
  logic                start = 1'b0;
  logic                busy;
  logic [ChanW-1:0]    red_i = '0;
  logic [ChanW-1:0]    green_i = '0;
  logic [ChanW-1:0]    blue_i = '0;
  logic                last_pixel_i = 1'b0;
  logic                done_o;
  logic [IndexW-1:0]   pixel_index_o;
  logic                new_entry_o;
  logic [CountW-1:0]   palette_count_o;
  logic [BppW-1:0]     bits_per_pixel_o;
  logic                transparent_found_o;
  logic [IndexW-1:0]   transparent_index_o;
  logic                last_out_o;

  pixel_word_t pending_pixels[$];
  index_word_t due_indices[$];
  int unsigned pixels_queued = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int          gap_max = 4;
  int          hold_left = 0;
  bit          grey_sel = 1'b0;

  // Predictor state and its copy of the configuration registers.
  logic              cfg_grey = 1'b0;
  logic              cfg_tr_enable = 1'b0;
  logic [ColorW-1:0] cfg_tr_color = '0;
  logic [ColorW-1:0] pal_colors[MaxPaletteSize];
  logic [CountW-1:0] pal_used = '0;
  logic              tr_hit = 1'b0;
  logic [IndexW-1:0] tr_slot = '0;

  palette_indexer u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .start,
    .busy,
    .red_i,
    .green_i,
    .blue_i,
    .last_pixel_i,
    .done_o,
    .pixel_index_o,
    .new_entry_o,
    .palette_count_o,
    .bits_per_pixel_o,
    .transparent_found_o,
    .transparent_index_o,
    .last_out_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic index_word_t index_pixel(input pixel_word_t px);
    index_word_t       res;
    logic [ColorW-1:0] color;
    int                i, c, d, best, ca, cb;
    bit                hit;
    color = cfg_grey ? {px.red, px.red, px.red} : {px.red, px.green, px.blue};
    res = '0;
    hit = 1'b0;
    for (i = 0; i < int'(pal_used) && !hit; i++) begin
      if (pal_colors[i] == color) begin
        res.pixel_index = IndexW'(i);
        hit = 1'b1;
      end
    end
    if (!hit && pal_used < MaxPaletteSize) begin
      res.pixel_index = IndexW'(pal_used);
      res.new_entry = 1'b1;
      pal_colors[pal_used] = color;
      if (cfg_tr_enable && !tr_hit && color == cfg_tr_color) begin
        tr_hit = 1'b1;
        tr_slot = IndexW'(pal_used);
      end
      pal_used = pal_used + 1'b1;
    end else if (!hit) begin
      // Full palette: nearest entry by L1 distance, the lowest index wins a tie.
      best = 1 << 30;
      for (i = 0; i < int'(pal_used); i++) begin
        d = 0;
        for (c = 0; c < ColorW; c += ChanW) begin
          ca = int'(color[c +: ChanW]);
          cb = int'(pal_colors[i][c +: ChanW]);
          d += (ca > cb) ? ca - cb : cb - ca;
        end
        if (d < best) begin
          best = d;
          res.pixel_index = IndexW'(i);
        end
      end
    end
    res.palette_count = pal_used;
    res.bpp = BppW'(1);
    while (res.bpp < 8 && (1 << res.bpp) < int'(pal_used)) res.bpp = res.bpp + 1'b1;
    res.tr_found = tr_hit;
    res.tr_index = tr_hit ? tr_slot : '0;
    res.last_out = px.last_pixel;
    if (px.last_pixel) begin
      pal_used = '0;
      tr_hit = 1'b0;
      tr_slot = '0;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input index_word_t want,
                               input index_word_t seen);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected idx=%0d new=%0d cnt=%0d bpp=%0d tf=%0d ti=%0d last=%0d",
               $realtime, what, want.pixel_index, want.new_entry, want.palette_count,
               want.bpp, want.tr_found, want.tr_index, want.last_out);
      $display("%0t %s: actual   idx=%0d new=%0d cnt=%0d bpp=%0d tf=%0d ti=%0d last=%0d",
               $realtime, what, seen.pixel_index, seen.new_entry, seen.palette_count,
               seen.bpp, seen.tr_found, seen.tr_index, seen.last_out);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    pixel_word_t px;
    if (!rst_ni) begin
      start <= 1'b0;
      red_i <= '0;
      green_i <= '0;
      blue_i <= '0;
      last_pixel_i <= 1'b0;
      hold_left <= 0;
    end else if (!start || !busy) begin
      if (hold_left == 0 && pending_pixels.size() != 0) begin
        px = pending_pixels.pop_front();
        red_i <= px.red;
        green_i <= px.green;
        blue_i <= px.blue;
        last_pixel_i <= px.last_pixel;
        start <= 1'b1;
        hold_left <= $urandom_range(0, gap_max);
      end else begin
        start <= 1'b0;
        if (hold_left != 0 && !busy) hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk_i) begin : index_monitor
    index_word_t seen, want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGreyscale: cfg_grey = cfg_data_i[0];
          RegTranspEnable: cfg_tr_enable = cfg_data_i[0];
          RegTranspColor: cfg_tr_color = cfg_data_i;
          default: ;
        endcase
      end
      if (done_o) begin
        seen = {pixel_index_o, new_entry_o, palette_count_o, bits_per_pixel_o,
                transparent_found_o, transparent_index_o, last_out_o};
        if (due_indices.size() == 0) begin
          flag_mismatch("unexpected word", '0, seen);
        end else begin
          want = due_indices.pop_front();
          if (seen !== want) flag_mismatch("wrong word", want, seen);
        end
      end
      if (start && !busy) begin
        due_indices.push_back(index_pixel({red_i, green_i, blue_i, last_pixel_i}));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("palette_indexer: mismatch");
      $finish;
    end
  end

  task automatic add_pixel(input logic [ColorW-1:0] color, input logic last);
    if (grey_sel) color[15:0] = 16'($urandom());
    pending_pixels.push_back({color, last});
    pixels_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || start || due_indices.size() != 0);
  endtask

  task automatic set_config(input bit grey, input bit tr_en, input logic [ColorW-1:0] tr_col,
                            input bit poke_unused);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegGreyscale;
    cfg_data_i <= {23'($urandom()), grey};
    @(posedge clk_i);
    cfg_idx_i <= RegTranspEnable;
    cfg_data_i <= {23'($urandom()), tr_en};
    @(posedge clk_i);
    cfg_idx_i <= RegTranspColor;
    cfg_data_i <= tr_col;
    if (poke_unused) begin
      @(posedge clk_i);
      cfg_idx_i <= RegUnused;
      cfg_data_i <= 24'($urandom());
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grey_sel = grey;
    @(negedge clk_i);
  endtask

  function automatic logic [ColorW-1:0] grid_color(input int k);
    k = k % 512;
    return {8'(36 * ((k >> 6) & 7)), 8'(36 * ((k >> 3) & 7)), 8'(36 * (k & 7))};
  endfunction

  initial begin
    int                p, n_img, len, pool_n, i, j, k0, step, pos, tmp;
    logic [ColorW-1:0] tcolor, col;
    logic [ColorW-1:0] pool[12];
    logic [ColorW-1:0] fill[256];
    int                grey_perm[256];
    logic [ChanW-1:0]  gv;
    bit                ten, keep_open;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_pixel(24'h000000, 1'b0);
    add_pixel(24'hFFFFFF, 1'b0);
    add_pixel(24'h000000, 1'b0);
    add_pixel(24'hFF0000, 1'b0);
    add_pixel(24'h00FF00, 1'b0);
    add_pixel(24'h0000FF, 1'b0);
    add_pixel(24'hAA55AA, 1'b0);
    add_pixel(24'h55AA55, 1'b0);
    add_pixel(24'hFFFFFF, 1'b1);
    add_pixel(24'h123456, 1'b1);
    wait_idle();
    set_config(1'b1, 1'b1, 24'h808080, 1'b0);
    add_pixel(24'h801357, 1'b0);
    add_pixel(24'h00FFFF, 1'b0);
    add_pixel(24'hFF0000, 1'b0);
    add_pixel(24'h80FF00, 1'b0);
    add_pixel(24'h000000, 1'b1);
    wait_idle();
    set_config(1'b0, 1'b1, 24'hFFFFFF, 1'b1);
    add_pixel(24'hFEFFFF, 1'b0);
    add_pixel(24'hFFFFFF, 1'b0);
    add_pixel(24'hFFFFFF, 1'b0);
    add_pixel(24'h000000, 1'b1);
    wait_idle();
    set_config(1'b0, 1'b0, 24'h000000, 1'b0);
    add_pixel(24'h000000, 1'b1);
    wait_idle();

    for (p = 1; pixels_queued < ItemsTarget || p <= 9; p++) begin
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
      grey_sel = bit'($urandom_range(0, 1));
      ten = ($urandom_range(0, 3) != 0);
      case (p % 4)
        0: tcolor = 24'h000000;
        1: tcolor = 24'hFFFFFF;
        2: tcolor = 24'($urandom());
        default: begin
          gv = 8'($urandom());
          tcolor = {gv, gv, gv};
        end
      endcase
      k0 = $urandom_range(0, 511);
      step = 2 * $urandom_range(0, 255) + 1;
      pos = $urandom_range(0, 255);
      if (p == 3 || p == 6) grey_sel = 1'b0;
      if (p == 6) tcolor = grid_color(k0 + step * pos);
      if (p == 9) begin
        grey_sel = 1'b1;
        gv = 8'($urandom());
        tcolor = {gv, gv, gv};
      end
      set_config(grey_sel, ten, tcolor, $urandom_range(0, 3) == 0);

      if (p == 3) begin
        for (i = 0; i < 256; i++) begin
          fill[i] = (i == pos) ? tcolor : 24'($urandom());
          add_pixel(fill[i], 1'b0);
        end
        for (i = 0; i < 40; i++) begin
          col = ($urandom_range(0, 1) == 0) ? fill[$urandom_range(0, 255)] : 24'($urandom());
          add_pixel(col, i == 39);
        end
      end else if (p == 6) begin
        // Coarse grid fill, then queries halfway between grid points so that ties are common.
        for (i = 0; i < 256; i++) add_pixel(grid_color(k0 + step * i), 1'b0);
        for (i = 0; i < 40; i++) begin
          col = {8'(18 * $urandom_range(0, 14)), 8'(18 * $urandom_range(0, 14)),
                 8'(18 * $urandom_range(0, 14))};
          add_pixel(col, i == 39);
        end
      end else if (p == 9) begin
        for (i = 0; i < 256; i++) grey_perm[i] = i;
        for (i = 255; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = grey_perm[i];
          grey_perm[i] = grey_perm[j];
          grey_perm[j] = tmp;
        end
        for (i = 0; i < 256; i++) add_pixel({8'(grey_perm[i]), 16'h0000}, 1'b0);
        for (i = 0; i < 20; i++) add_pixel(24'($urandom()), i == 19);
      end else begin
        keep_open = ($urandom_range(0, 3) == 0);
        n_img = $urandom_range(1, 6);
        for (j = 0; j < n_img; j++) begin
          len = $urandom_range(1, 40);
          pool_n = $urandom_range(1, 12);
          for (i = 0; i < pool_n; i++) pool[i] = 24'($urandom());
          if ($urandom_range(0, 2) == 0) pool[$urandom_range(0, pool_n - 1)] = tcolor;
          for (i = 0; i < len; i++) begin
            col = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, pool_n - 1)]
                                              : 24'($urandom());
            add_pixel(col, i == len - 1 && !(j == n_img - 1 && keep_open));
          end
        end
      end
      wait_idle();
    end

    repeat (MaxPaletteSize + 8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("palette_indexer: match");
    end else begin
      $display("palette_indexer: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pal_idx_pkg.sv
design/pal_idx_cell.sv
design/palette_indexer.sv
verif/palette_indexer_tb.sv
